// ----- hw/rtl/ata_pio_command_issuer_assert.svh -----
// assertion macros shared by the issuer rtl
`ifndef ATA_PIO_COMMAND_ISSUER_ASSERT_SVH
`define ATA_PIO_COMMAND_ISSUER_ASSERT_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define APCI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off while arst_n is low
`define APCI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/apci_pkg.sv -----
`default_nettype none

package apci_pkg;

	// field widths
	localparam int unsigned FUNC_W   = 2;
	localparam int unsigned SECTOR_W = 48;
	localparam int unsigned COUNT_W  = 32;
	localparam int unsigned IDX_W    = 3;
	localparam int unsigned VAL_W    = 8;
	localparam int unsigned STAT_W   = 3;
	localparam int unsigned CFG_IX_W = 2;
	localparam int unsigned CFG_D_W  = 48;

	localparam int unsigned APCI_CHUNK_MAX = 255;
	localparam logic [SECTOR_W:0] LBA28_LIMIT = 49'h0_0000_0FFF_FFFF;

	// request functions
	localparam logic [FUNC_W-1:0] FN_READ  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_WRITE = 2'd1;
	localparam logic [FUNC_W-1:0] FN_NEXT  = 2'd2;
	localparam logic [FUNC_W-1:0] FN_FLUSH = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IX_W-1:0] CFG_DEV_PRESENT = 2'd0;
	localparam logic [CFG_IX_W-1:0] CFG_CAPACITY    = 2'd1;
	localparam logic [CFG_IX_W-1:0] CFG_TRACK_SECT  = 2'd2;
	localparam logic [CFG_IX_W-1:0] CFG_HEAD_COUNT  = 2'd3;

	// task-file register indexes
	localparam logic [IDX_W-1:0] TF_DEVSEL  = 3'd0;
	localparam logic [IDX_W-1:0] TF_SECCNT  = 3'd1;
	localparam logic [IDX_W-1:0] TF_LBA_LO  = 3'd2;
	localparam logic [IDX_W-1:0] TF_LBA_MID = 3'd3;
	localparam logic [IDX_W-1:0] TF_LBA_HI  = 3'd4;
	localparam logic [IDX_W-1:0] TF_COMMAND = 3'd5;

	// result status codes
	localparam logic [STAT_W-1:0] ST_CHUNK   = 3'd0;
	localparam logic [STAT_W-1:0] ST_FINAL   = 3'd1;
	localparam logic [STAT_W-1:0] ST_NO_DEV  = 3'd2;
	localparam logic [STAT_W-1:0] ST_UNSUP   = 3'd3;
	localparam logic [STAT_W-1:0] ST_RANGE   = 3'd4;
	localparam logic [STAT_W-1:0] ST_IDLE    = 3'd5;
	localparam logic [STAT_W-1:0] ST_FLUSHED = 3'd6;

	// ata command and device bytes
	localparam logic [VAL_W-1:0] ATA_DEV_CHS   = 8'hB0;
	localparam logic [VAL_W-1:0] ATA_DEV_LBA   = 8'hF0;
	localparam logic [VAL_W-1:0] ATA_READ      = 8'h20;
	localparam logic [VAL_W-1:0] ATA_READ_EXT  = 8'h24;
	localparam logic [VAL_W-1:0] ATA_WRITE     = 8'h30;
	localparam logic [VAL_W-1:0] ATA_WRITE_EXT = 8'h34;
	localparam logic [VAL_W-1:0] ATA_FLUSH     = 8'hE7;
	localparam logic [VAL_W-1:0] ATA_FLUSH_EXT = 8'hEA;

	// micro-ops
	localparam int unsigned OP_W = 4;
	localparam logic [OP_W-1:0] OP_IDLE   = 4'd0;
	localparam logic [OP_W-1:0] OP_JUMP   = 4'd1;
	localparam logic [OP_W-1:0] OP_END    = 4'd2;
	localparam logic [OP_W-1:0] OP_LOAD   = 4'd3;
	localparam logic [OP_W-1:0] OP_CHUNK  = 4'd4;
	localparam logic [OP_W-1:0] OP_COMMIT = 4'd5;
	localparam logic [OP_W-1:0] OP_DIV1   = 4'd6;
	localparam logic [OP_W-1:0] OP_DIV2   = 4'd7;
	localparam logic [OP_W-1:0] OP_EMIT   = 4'd8;
	localparam logic [OP_W-1:0] OP_REPORT = 4'd9;

	// jump conditions
	localparam int unsigned COND_W = 4;
	localparam logic [COND_W-1:0] C_ALWAYS     = 4'd0;
	localparam logic [COND_W-1:0] C_FLUSH      = 4'd1;
	localparam logic [COND_W-1:0] C_NEXT       = 4'd2;
	localparam logic [COND_W-1:0] C_NO_DEV     = 4'd3;
	localparam logic [COND_W-1:0] C_NOT_ACTIVE = 4'd4;
	localparam logic [COND_W-1:0] C_CHS_BAD    = 4'd5;
	localparam logic [COND_W-1:0] C_RANGE      = 4'd6;
	localparam logic [COND_W-1:0] C_CNT_ZERO   = 4'd7;
	localparam logic [COND_W-1:0] C_IS_CHS     = 4'd8;
	localparam logic [COND_W-1:0] C_LBA28      = 4'd9;

	// emitted byte sources
	localparam int unsigned VSEL_W = 5;
	localparam logic [VSEL_W-1:0] V_ZERO   = 5'd0;
	localparam logic [VSEL_W-1:0] V_F0     = 5'd1;
	localparam logic [VSEL_W-1:0] V_N      = 5'd2;
	localparam logic [VSEL_W-1:0] V_S0     = 5'd3;
	localparam logic [VSEL_W-1:0] V_S1     = 5'd4;
	localparam logic [VSEL_W-1:0] V_S2     = 5'd5;
	localparam logic [VSEL_W-1:0] V_S3     = 5'd6;
	localparam logic [VSEL_W-1:0] V_S4     = 5'd7;
	localparam logic [VSEL_W-1:0] V_S5     = 5'd8;
	localparam logic [VSEL_W-1:0] V_DEV28  = 5'd9;
	localparam logic [VSEL_W-1:0] V_DEVCHS = 5'd10;
	localparam logic [VSEL_W-1:0] V_SEC    = 5'd11;
	localparam logic [VSEL_W-1:0] V_CYL_LO = 5'd12;
	localparam logic [VSEL_W-1:0] V_CYL_HI = 5'd13;
	localparam logic [VSEL_W-1:0] V_CMD28  = 5'd14;
	localparam logic [VSEL_W-1:0] V_CMD48  = 5'd15;
	localparam logic [VSEL_W-1:0] V_FLUSH  = 5'd16;

	// sectors_left sources
	localparam int unsigned LSEL_W = 2;
	localparam logic [LSEL_W-1:0] L_ZERO = 2'd0;
	localparam logic [LSEL_W-1:0] L_REM  = 2'd1;
	localparam logic [LSEL_W-1:0] L_LEFT = 2'd2;

	// program labels
	localparam int unsigned PC_W = 6;
	localparam logic [PC_W-1:0] P_IDLE      = 6'd0;
	localparam logic [PC_W-1:0] P_CHUNK     = 6'd9;
	localparam logic [PC_W-1:0] P_L28       = 6'd23;
	localparam logic [PC_W-1:0] P_CHS       = 6'd29;
	localparam logic [PC_W-1:0] P_NEXT      = 6'd37;
	localparam logic [PC_W-1:0] P_NODEV_END = 6'd41;
	localparam logic [PC_W-1:0] P_NODEV     = 6'd42;
	localparam logic [PC_W-1:0] P_UNSUP_END = 6'd43;
	localparam logic [PC_W-1:0] P_UNSUP     = 6'd44;
	localparam logic [PC_W-1:0] P_RANGE     = 6'd45;
	localparam logic [PC_W-1:0] P_EMPTY     = 6'd46;
	localparam logic [PC_W-1:0] P_IDLE_RPT  = 6'd47;
	localparam logic [PC_W-1:0] P_FLUSH     = 6'd48;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [COND_W-1:0] cond;
		logic [PC_W-1:0]   target;
		logic [IDX_W-1:0]  idx;
		logic [VSEL_W-1:0] vsel;
		logic [STAT_W-1:0] stat;
		logic [LSEL_W-1:0] lsel;
		logic              last;
	} ucode_t;

	// plain datapath step
	function automatic ucode_t u_op(input logic [OP_W-1:0] op);
		ucode_t w;
		w = '0;
		w.op = op;
		return w;
	endfunction

	// conditional jump
	function automatic ucode_t u_jmp(input logic [COND_W-1:0] cond,
			input logic [PC_W-1:0] target);
		ucode_t w;
		w = '0;
		w.op = OP_JUMP;
		w.cond = cond;
		w.target = target;
		return w;
	endfunction

	// task-file write item of a chunk
	function automatic ucode_t u_wr(input logic [IDX_W-1:0] idx,
			input logic [VSEL_W-1:0] vsel, input logic last);
		ucode_t w;
		w = '0;
		w.op = OP_EMIT;
		w.idx = idx;
		w.vsel = vsel;
		w.lsel = L_LEFT;
		w.last = last;
		return w;
	endfunction

	// task-file write item of a flush
	function automatic ucode_t u_fl(input logic [IDX_W-1:0] idx,
			input logic [VSEL_W-1:0] vsel, input logic last);
		ucode_t w;
		w = '0;
		w.op = OP_EMIT;
		w.idx = idx;
		w.vsel = vsel;
		w.stat = ST_FLUSHED;
		w.lsel = L_REM;
		w.last = last;
		return w;
	endfunction

	// single status item
	function automatic ucode_t u_rpt(input logic [STAT_W-1:0] stat);
		ucode_t w;
		w = '0;
		w.op = OP_REPORT;
		w.stat = stat;
		w.last = 1'b1;
		return w;
	endfunction

	// control store
	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		case (pc)
			6'd0:  w = u_op(OP_IDLE);
			6'd1:  w = u_jmp(C_FLUSH, P_FLUSH);
			6'd2:  w = u_jmp(C_NEXT, P_NEXT);
			// start read / write
			6'd3:  w = u_op(OP_END);
			6'd4:  w = u_jmp(C_NO_DEV, P_NODEV);
			6'd5:  w = u_jmp(C_CHS_BAD, P_UNSUP);
			6'd6:  w = u_jmp(C_RANGE, P_RANGE);
			6'd7:  w = u_jmp(C_CNT_ZERO, P_EMPTY);
			6'd8:  w = u_op(OP_LOAD);
			// chunk issue
			6'd9:  w = u_op(OP_CHUNK);
			6'd10: w = u_op(OP_COMMIT);
			6'd11: w = u_jmp(C_IS_CHS, P_CHS);
			6'd12: w = u_jmp(C_LBA28, P_L28);
			// lba48
			6'd13: w = u_wr(TF_DEVSEL, V_F0, 1'b0);
			6'd14: w = u_wr(TF_SECCNT, V_ZERO, 1'b0);
			6'd15: w = u_wr(TF_LBA_LO, V_S3, 1'b0);
			6'd16: w = u_wr(TF_LBA_MID, V_S4, 1'b0);
			6'd17: w = u_wr(TF_LBA_HI, V_S5, 1'b0);
			6'd18: w = u_wr(TF_SECCNT, V_N, 1'b0);
			6'd19: w = u_wr(TF_LBA_LO, V_S0, 1'b0);
			6'd20: w = u_wr(TF_LBA_MID, V_S1, 1'b0);
			6'd21: w = u_wr(TF_LBA_HI, V_S2, 1'b0);
			6'd22: w = u_wr(TF_COMMAND, V_CMD48, 1'b1);
			// lba28
			6'd23: w = u_wr(TF_DEVSEL, V_DEV28, 1'b0);
			6'd24: w = u_wr(TF_SECCNT, V_N, 1'b0);
			6'd25: w = u_wr(TF_LBA_LO, V_S0, 1'b0);
			6'd26: w = u_wr(TF_LBA_MID, V_S1, 1'b0);
			6'd27: w = u_wr(TF_LBA_HI, V_S2, 1'b0);
			6'd28: w = u_wr(TF_COMMAND, V_CMD28, 1'b1);
			// chs
			6'd29: w = u_op(OP_DIV1);
			6'd30: w = u_op(OP_DIV2);
			6'd31: w = u_wr(TF_DEVSEL, V_DEVCHS, 1'b0);
			6'd32: w = u_wr(TF_SECCNT, V_N, 1'b0);
			6'd33: w = u_wr(TF_LBA_LO, V_SEC, 1'b0);
			6'd34: w = u_wr(TF_LBA_MID, V_CYL_LO, 1'b0);
			6'd35: w = u_wr(TF_LBA_HI, V_CYL_HI, 1'b0);
			6'd36: w = u_wr(TF_COMMAND, V_CMD28, 1'b1);
			// next chunk
			6'd37: w = u_jmp(C_NOT_ACTIVE, P_IDLE_RPT);
			6'd38: w = u_jmp(C_NO_DEV, P_NODEV_END);
			6'd39: w = u_jmp(C_CHS_BAD, P_UNSUP_END);
			6'd40: w = u_jmp(C_ALWAYS, P_CHUNK);
			// status reports
			6'd41: w = u_op(OP_END);
			6'd42: w = u_rpt(ST_NO_DEV);
			6'd43: w = u_op(OP_END);
			6'd44: w = u_rpt(ST_UNSUP);
			6'd45: w = u_rpt(ST_RANGE);
			6'd46: w = u_rpt(ST_FINAL);
			6'd47: w = u_rpt(ST_IDLE);
			// flush
			6'd48: w = u_jmp(C_NO_DEV, P_NODEV);
			6'd49: w = u_fl(TF_DEVSEL, V_F0, 1'b0);
			6'd50: w = u_fl(TF_COMMAND, V_FLUSH, 1'b1);
			default: w = u_jmp(C_ALWAYS, P_IDLE);
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/apci_if.sv -----
`default_nettype none

// request channel
interface apci_req_if import apci_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [SECTOR_W-1:0] start_sector;
	logic [COUNT_W-1:0]  sector_count;

	modport source (output valid, output func, output start_sector, output sector_count,
		input ready);
	modport sink (input valid, input func, input start_sector, input sector_count,
		output ready);
endinterface

// result channel
interface apci_rsp_if import apci_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               reg_write;
	logic [IDX_W-1:0]   reg_index;
	logic [VAL_W-1:0]   reg_value;
	logic [STAT_W-1:0]  status;
	logic [COUNT_W-1:0] sectors_left;
	logic               last;

	modport source (output valid, output reg_write, output reg_index, output reg_value,
		output status, output sectors_left, output last, input ready);
	modport sink (input valid, input reg_write, input reg_index, input reg_value,
		input status, input sectors_left, input last, output ready);
endinterface

// configuration write channel
interface apci_cfg_if import apci_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CFG_IX_W-1:0] index;
	logic [CFG_D_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ata_pio_command_issuer.sv -----
// channel | role | payload
// req     | sink   | func, start_sector, sector_count
// rsp     | source | reg_write, reg_index, reg_value, status, sectors_left, last
// cfg     | sink   | index, data (always ready)
//
// one control step per cycle from the microcode table, but a divide step holds until
// its division is done; a request is taken only at the idle step. a chs chunk runs
// the shared 1-bit-per-cycle divider twice: sector by track_sectors, then the
// quotient by head_count.
// arst_n clears the step counter, active, writing, remaining, config and the result valid.
// an emit step holds while rsp is full and not taken; a new request may be taken
// while the last result still waits in the output register.
`default_nettype none

`include "ata_pio_command_issuer_assert.svh"

module ata_pio_command_issuer import apci_pkg::*; #(
	parameter int unsigned CHUNK_MAX = APCI_CHUNK_MAX
) (
	input  wire        clk,
	input  wire        arst_n,
	apci_req_if.sink   req,
	apci_rsp_if.source rsp,
	apci_cfg_if.sink   cfg
);

	localparam logic [VAL_W-1:0]   CHUNK_B  = VAL_W'(CHUNK_MAX);
	localparam logic [COUNT_W-1:0] CHUNK_C  = COUNT_W'(CHUNK_MAX);
	localparam int unsigned        DIV_LAST = SECTOR_W - 1;

	// sequencer
	logic [PC_W-1:0] pc_q;
	ucode_t          uw;

	// configuration
	logic                dev_present_q;
	logic [SECTOR_W-1:0] capacity_q;
	logic [VAL_W-1:0]    track_q;
	logic [4:0]          heads_q;

	// transfer state
	logic                active_q;
	logic                writing_q;
	logic [SECTOR_W-1:0] next_sector_q;
	logic [COUNT_W-1:0]  remaining_q;

	// latched request
	logic [FUNC_W-1:0]   func_q;
	logic [SECTOR_W-1:0] start_q;
	logic [COUNT_W-1:0]  count_q;

	// chunk working set
	logic [SECTOR_W-1:0] s_q;
	logic [VAL_W-1:0]    n_q;
	logic [COUNT_W-1:0]  left_q;
	logic [SECTOR_W:0]   sum_q;
	logic [VAL_W-1:0]    sec_q;

	// shared divider
	logic                div_run_q;
	logic [5:0]          div_cnt_q;
	logic [SECTOR_W-1:0] quo_q;
	logic [VAL_W-1:0]    rem_q;
	logic [VAL_W-1:0]    div_d_q;
	logic [VAL_W:0]      div_sh;
	logic                div_ge;
	logic [VAL_W:0]      div_diff;

	// output register
	logic               rsp_valid_q;
	logic               rsp_write_q;
	logic [IDX_W-1:0]   rsp_index_q;
	logic [VAL_W-1:0]   rsp_value_q;
	logic [STAT_W-1:0]  rsp_status_q;
	logic [COUNT_W-1:0] rsp_left_q;
	logic               rsp_last_q;

	logic               emit_ok;
	logic               emit_fire;
	logic               cond_hit;
	logic               is_chs;
	logic               chs_bad;
	logic [SECTOR_W:0]  req_end;
	logic [VAL_W-1:0]   emit_val;
	logic [COUNT_W-1:0] emit_left;
	logic [STAT_W-1:0]  emit_stat;
	logic [VAL_W-1:0]   n_next;

	assign uw = ucode_rom(pc_q);

	assign req.ready = (uw.op == OP_IDLE);
	assign cfg.ready = 1'b1;

	assign rsp.valid        = rsp_valid_q;
	assign rsp.reg_write    = rsp_write_q;
	assign rsp.reg_index    = rsp_index_q;
	assign rsp.reg_value    = rsp_value_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.sectors_left = rsp_left_q;
	assign rsp.last         = rsp_last_q;

	assign emit_ok   = !rsp_valid_q || rsp.ready;
	assign emit_fire = (uw.op == OP_EMIT || uw.op == OP_REPORT) && emit_ok;

	// condition evaluation
	assign is_chs  = (capacity_q == '0);
	assign chs_bad = is_chs && (track_q == '0 || heads_q == '0);
	assign req_end = {1'b0, start_q} + {{(SECTOR_W + 1 - COUNT_W){1'b0}}, count_q};

	always_comb begin
		unique case (uw.cond)
			C_ALWAYS:     cond_hit = 1'b1;
			C_FLUSH:      cond_hit = (func_q == FN_FLUSH);
			C_NEXT:       cond_hit = (func_q == FN_NEXT);
			C_NO_DEV:     cond_hit = !dev_present_q;
			C_NOT_ACTIVE: cond_hit = !active_q;
			C_CHS_BAD:    cond_hit = chs_bad;
			C_RANGE:      cond_hit = !is_chs && (req_end > {1'b0, capacity_q});
			C_CNT_ZERO:   cond_hit = (count_q == '0);
			C_IS_CHS:     cond_hit = is_chs;
			C_LBA28:      cond_hit = (sum_q <= LBA28_LIMIT);
			default:      cond_hit = 1'b0;
		endcase
	end

	// emitted byte selection
	always_comb begin
		unique case (uw.vsel)
			V_ZERO:   emit_val = '0;
			V_F0:     emit_val = ATA_DEV_LBA;
			V_N:      emit_val = n_q;
			V_S0:     emit_val = s_q[7:0];
			V_S1:     emit_val = s_q[15:8];
			V_S2:     emit_val = s_q[23:16];
			V_S3:     emit_val = s_q[31:24];
			V_S4:     emit_val = s_q[39:32];
			V_S5:     emit_val = s_q[47:40];
			V_DEV28:  emit_val = ATA_DEV_LBA | {4'h0, s_q[27:24]};
			V_DEVCHS: emit_val = ATA_DEV_CHS | {4'h0, rem_q[3:0]};
			V_SEC:    emit_val = sec_q;
			V_CYL_LO: emit_val = quo_q[7:0];
			V_CYL_HI: emit_val = quo_q[15:8];
			V_CMD28:  emit_val = writing_q ? ATA_WRITE : ATA_READ;
			V_CMD48:  emit_val = writing_q ? ATA_WRITE_EXT : ATA_READ_EXT;
			V_FLUSH:  emit_val = (capacity_q[SECTOR_W-1:28] != '0) ? ATA_FLUSH_EXT : ATA_FLUSH;
			default:  emit_val = '0;
		endcase
	end

	// sectors_left and status selection
	always_comb begin
		unique case (uw.lsel)
			L_REM:   emit_left = remaining_q;
			L_LEFT:  emit_left = left_q;
			default: emit_left = '0;
		endcase
		if (uw.lsel == L_LEFT) begin
			emit_stat = (left_q == '0) ? ST_FINAL : ST_CHUNK;
		end else begin
			emit_stat = uw.stat;
		end
	end

	// chunk size
	assign n_next = (remaining_q > CHUNK_C) ? CHUNK_B : remaining_q[VAL_W-1:0];

	// restoring divider step
	assign div_sh   = {rem_q, quo_q[SECTOR_W-1]};
	assign div_diff = div_sh - {1'b0, div_d_q};
	assign div_ge   = (div_sh >= {1'b0, div_d_q});

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_present_q <= 1'b0;
			capacity_q    <= '0;
			track_q       <= '0;
			heads_q       <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_DEV_PRESENT: dev_present_q <= cfg.data[0];
				CFG_CAPACITY:    capacity_q    <= cfg.data[SECTOR_W-1:0];
				CFG_TRACK_SECT:  track_q       <= cfg.data[VAL_W-1:0];
				CFG_HEAD_COUNT:  heads_q       <= cfg.data[4:0];
				default: ;
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= P_IDLE;
			active_q    <= 1'b0;
			writing_q   <= 1'b0;
			remaining_q <= '0;
			div_run_q   <= 1'b0;
			div_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// output register fills on an emit, empties when taken
			if (emit_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (uw.op)
				OP_IDLE: begin
					if (req.valid) begin
						pc_q <= pc_q + 1'b1;
					end
				end
				OP_JUMP: begin
					pc_q <= cond_hit ? uw.target : pc_q + 1'b1;
				end
				OP_END: begin
					active_q    <= 1'b0;
					remaining_q <= '0;
					pc_q        <= pc_q + 1'b1;
				end
				OP_LOAD: begin
					writing_q   <= (func_q == FN_WRITE);
					remaining_q <= count_q;
					active_q    <= 1'b1;
					pc_q        <= pc_q + 1'b1;
				end
				OP_CHUNK: begin
					pc_q <= pc_q + 1'b1;
				end
				OP_COMMIT: begin
					remaining_q <= left_q;
					if (left_q == '0) begin
						active_q <= 1'b0;
					end
					pc_q <= pc_q + 1'b1;
				end
				OP_DIV1, OP_DIV2: begin
					if (!div_run_q) begin
						div_run_q <= 1'b1;
						div_cnt_q <= '0;
					end else if (div_cnt_q == 6'(DIV_LAST)) begin
						div_run_q <= 1'b0;
						pc_q      <= pc_q + 1'b1;
					end else begin
						div_cnt_q <= div_cnt_q + 1'b1;
					end
				end
				OP_EMIT, OP_REPORT: begin
					if (emit_ok) begin
						pc_q <= uw.last ? P_IDLE : pc_q + 1'b1;
					end
				end
				default: pc_q <= P_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (uw.op == OP_IDLE && req.valid) begin
			func_q  <= req.func;
			start_q <= req.start_sector;
			count_q <= req.sector_count;
		end
		if (uw.op == OP_LOAD) begin
			next_sector_q <= start_q;
		end
		if (uw.op == OP_CHUNK) begin
			s_q    <= next_sector_q;
			n_q    <= n_next;
			left_q <= remaining_q - {{(COUNT_W - VAL_W){1'b0}}, n_next};
			sum_q  <= {1'b0, next_sector_q} + {{(SECTOR_W + 1 - VAL_W){1'b0}}, n_next};
		end
		if (uw.op == OP_COMMIT) begin
			next_sector_q <= sum_q[SECTOR_W-1:0];
		end
		// divider: s / track_sectors, then quotient / head_count
		if ((uw.op == OP_DIV1 || uw.op == OP_DIV2) && !div_run_q) begin
			quo_q   <= (uw.op == OP_DIV1) ? s_q : quo_q;
			div_d_q <= (uw.op == OP_DIV1) ? track_q : {3'b000, heads_q};
			rem_q   <= '0;
		end else if (div_run_q) begin
			quo_q <= {quo_q[SECTOR_W-2:0], div_ge};
			rem_q <= div_ge ? div_diff[VAL_W-1:0] : div_sh[VAL_W-1:0];
		end
		if (uw.op == OP_DIV2 && !div_run_q) begin
			sec_q <= rem_q + 1'b1;
		end
		// result item
		if (emit_fire) begin
			rsp_write_q  <= (uw.op == OP_EMIT);
			rsp_index_q  <= uw.idx;
			rsp_value_q  <= (uw.op == OP_EMIT) ? emit_val : '0;
			rsp_status_q <= emit_stat;
			rsp_left_q   <= emit_left;
			rsp_last_q   <= uw.last;
		end
	end

	// checks
	`APCI_ASSERT_NOW(a_div_only_in_div_step, div_run_q,
		(uw.op == OP_DIV1) || (uw.op == OP_DIV2), "divider running outside a divide step")
	`APCI_ASSERT_NOW(a_idle_has_no_remaining, !active_q, remaining_q == '0,
		"sectors remain while no transfer is active")
	`APCI_ASSERT_NOW(a_final_chunk_empty,
		rsp.valid && rsp.reg_write && (rsp.status == ST_FINAL), rsp.sectors_left == '0,
		"final chunk item reports sectors left")

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none

module testbench;
	import apci_pkg::*;

	localparam int CLK_HALF       = 4;
	localparam int TIMEOUT_CYCLES = 2000000;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 16;
	localparam int TAIL_CYCLES    = 200;
	localparam int RANDOM_ITEMS   = 440;

	// one task-file item as seen on the result channel
	typedef struct packed {
		logic               reg_write;
		logic [IDX_W-1:0]   reg_index;
		logic [VAL_W-1:0]   reg_value;
		logic [STAT_W-1:0]  status;
		logic [COUNT_W-1:0] sectors_left;
		logic               last;
	} tf_item_t;

	// predicts the task-file items of each request and checks what comes out
	class taskfile_scoreboard;
		bit                  dev_present = 0;
		logic [SECTOR_W-1:0] capacity    = '0;
		logic [7:0]          trk         = '0;
		logic [4:0]          heads       = '0;
		bit                  active      = 0;
		bit                  writing     = 0;
		logic [SECTOR_W-1:0] next_sec    = '0;
		logic [COUNT_W-1:0]  remaining   = '0;
		tf_item_t            due_items[$];
		int                  errors      = 0;

		function void set_reg(logic [CFG_IX_W-1:0] ix, logic [CFG_D_W-1:0] d);
			case (ix)
				CFG_DEV_PRESENT: dev_present = d[0];
				CFG_CAPACITY:    capacity = d;
				CFG_TRACK_SECT:  trk = d[7:0];
				CFG_HEAD_COUNT:  heads = d[4:0];
				default: ;
			endcase
		endfunction

		function void post(logic wr, logic [IDX_W-1:0] ix, logic [VAL_W-1:0] v,
				logic [STAT_W-1:0] st, logic [COUNT_W-1:0] left, logic lst);
			tf_item_t it;
			it = '{wr, ix, v, st, left, lst};
			due_items.push_back(it);
		endfunction

		// status-only answer, the single item of its request
		function void report(logic [STAT_W-1:0] st);
			post(1'b0, '0, '0, st, '0, 1'b1);
		endfunction

		// ST_CHUNK here means a chunk may go
		function logic [STAT_W-1:0] chunk_fault();
			if (!dev_present)
				return ST_NO_DEV;
			if (capacity == 0 && (trk == 0 || heads == 0))
				return ST_UNSUP;
			return ST_CHUNK;
		endfunction

		function void issue_chunk();
			logic [COUNT_W-1:0]  n, left;
			logic [SECTOR_W-1:0] s;
			logic [63:0]         s64, span, cyl, hd, sec;
			logic [STAT_W-1:0]   st;
			logic [VAL_W-1:0]    cmd;
			n = (remaining > APCI_CHUNK_MAX) ? APCI_CHUNK_MAX : remaining;
			s = next_sec;
			s64 = {16'b0, s};
			left = remaining - n;
			st = (left == 0) ? ST_FINAL : ST_CHUNK;
			cmd = writing ? ATA_WRITE : ATA_READ;
			if (capacity == 0) begin
				// chs: cylinder keeps only 16 bits
				span = {56'b0, trk} * {59'b0, heads};
				cyl = s64 / span;
				hd = (s64 / {56'b0, trk}) % {59'b0, heads};
				sec = (s64 % {56'b0, trk}) + 1;
				post(1'b1, TF_DEVSEL, ATA_DEV_CHS | {4'b0, hd[3:0]}, st, left, 1'b0);
				post(1'b1, TF_SECCNT, n[7:0], st, left, 1'b0);
				post(1'b1, TF_LBA_LO, sec[7:0], st, left, 1'b0);
				post(1'b1, TF_LBA_MID, cyl[7:0], st, left, 1'b0);
				post(1'b1, TF_LBA_HI, cyl[15:8], st, left, 1'b0);
				post(1'b1, TF_COMMAND, cmd, st, left, 1'b1);
			end else if (s64 + {32'b0, n} <= {15'b0, LBA28_LIMIT}) begin
				post(1'b1, TF_DEVSEL, ATA_DEV_LBA | {4'b0, s[27:24]}, st, left, 1'b0);
				post(1'b1, TF_SECCNT, n[7:0], st, left, 1'b0);
				post(1'b1, TF_LBA_LO, s[7:0], st, left, 1'b0);
				post(1'b1, TF_LBA_MID, s[15:8], st, left, 1'b0);
				post(1'b1, TF_LBA_HI, s[23:16], st, left, 1'b0);
				post(1'b1, TF_COMMAND, cmd, st, left, 1'b1);
			end else begin
				// lba48: high bytes first, then low bytes
				cmd = writing ? ATA_WRITE_EXT : ATA_READ_EXT;
				post(1'b1, TF_DEVSEL, ATA_DEV_LBA, st, left, 1'b0);
				post(1'b1, TF_SECCNT, 8'h00, st, left, 1'b0);
				post(1'b1, TF_LBA_LO, s[31:24], st, left, 1'b0);
				post(1'b1, TF_LBA_MID, s[39:32], st, left, 1'b0);
				post(1'b1, TF_LBA_HI, s[47:40], st, left, 1'b0);
				post(1'b1, TF_SECCNT, n[7:0], st, left, 1'b0);
				post(1'b1, TF_LBA_LO, s[7:0], st, left, 1'b0);
				post(1'b1, TF_LBA_MID, s[15:8], st, left, 1'b0);
				post(1'b1, TF_LBA_HI, s[23:16], st, left, 1'b0);
				post(1'b1, TF_COMMAND, cmd, st, left, 1'b1);
			end
			next_sec = s + {16'b0, n};
			remaining = left;
			if (left == 0)
				active = 0;
		endfunction

		function void note_request(logic [FUNC_W-1:0] f, logic [SECTOR_W-1:0] start,
				logic [COUNT_W-1:0] count);
			logic [STAT_W-1:0] fault;
			logic [VAL_W-1:0]  cmd;
			if (f == FN_FLUSH) begin
				if (!dev_present) begin
					report(ST_NO_DEV);
				end else begin
					cmd = ({1'b0, capacity} > LBA28_LIMIT) ? ATA_FLUSH_EXT : ATA_FLUSH;
					post(1'b1, TF_DEVSEL, ATA_DEV_LBA, ST_FLUSHED, remaining, 1'b0);
					post(1'b1, TF_COMMAND, cmd, ST_FLUSHED, remaining, 1'b1);
				end
			end else if (f == FN_NEXT) begin
				if (!active) begin
					report(ST_IDLE);
				end else begin
					fault = chunk_fault();
					if (fault != ST_CHUNK) begin
						active = 0;
						remaining = '0;
						report(fault);
					end else begin
						issue_chunk();
					end
				end
			end else begin
				// a start always drops the transfer in progress
				active = 0;
				remaining = '0;
				fault = chunk_fault();
				if (fault != ST_CHUNK) begin
					report(fault);
				end else if (capacity != 0 &&
						{16'b0, start} + {32'b0, count} > {16'b0, capacity}) begin
					report(ST_RANGE);
				end else if (count == 0) begin
					report(ST_FINAL);
				end else begin
					writing = (f == FN_WRITE);
					next_sec = start;
					remaining = count;
					active = 1;
					issue_chunk();
				end
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
			end
		endfunction

		function void check_item(tf_item_t got);
			tf_item_t want;
			if (due_items.size() == 0) begin
				errors++;
				$display("%0t unexpected item: expected none, actual %0h", $time, got);
			end else begin
				want = due_items.pop_front();
				compare_field("reg_write", want.reg_write, got.reg_write);
				compare_field("reg_index", want.reg_index, got.reg_index);
				compare_field("reg_value", want.reg_value, got.reg_value);
				compare_field("status", want.status, got.status);
				compare_field("sectors_left", want.sectors_left, got.sectors_left);
				compare_field("last", want.last, got.last);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	apci_req_if req_ch ();
	apci_rsp_if rsp_ch ();
	apci_cfg_if cfg_ch ();

	ata_pio_command_issuer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	taskfile_scoreboard sb;
	bit burst     = 0;
	bit hold_flag = 0;
	int items_sent = 0;

	// clock
	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	// known input values, then reset
	initial begin
		sb = new;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func = '0;
		req_ch.start_sector = '0;
		req_ch.sector_count = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// run limit
	initial begin
		#(TIMEOUT_CYCLES * 2 * CLK_HALF);
		$display("status: fail");
		$finish;
	end

	function automatic logic [SECTOR_W-1:0] rand48();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[SECTOR_W-1:0];
	endfunction

	// offer one request after a random gap, wait for it to be taken
	task automatic send_request(logic [FUNC_W-1:0] f, logic [SECTOR_W-1:0] s,
			logic [COUNT_W-1:0] c);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= f;
		req_ch.start_sector <= s;
		req_ch.sector_count <= c;
		do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
		sb.note_request(f, s, c);
		items_sent++;
	endtask

	task automatic set_register(logic [CFG_IX_W-1:0] ix, logic [CFG_D_W-1:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= ix;
		cfg_ch.data <= d;
		do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
		sb.set_reg(ix, d);
	endtask

	// all four registers; unused upper data bits carry junk
	task automatic write_regs(bit dev, logic [SECTOR_W-1:0] cap, logic [7:0] ts,
			logic [4:0] hc);
		logic [SECTOR_W-1:0] junk;
		junk = rand48();
		set_register(CFG_DEV_PRESENT, {junk[47:1], dev});
		set_register(CFG_CAPACITY, cap);
		set_register(CFG_TRACK_SECT, {junk[47:8], ts});
		set_register(CFG_HEAD_COUNT, {junk[47:5], hc});
		cfg_ch.valid <= 1'b0;
	endtask

	// sender pause until every predicted item has come out
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (sb.due_items.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [COUNT_W-1:0] pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 15)
			return $urandom;
		if (r < 30)
			return $urandom_range(1, 255);
		return $urandom_range(1, 1200);
	endfunction

	function automatic logic [SECTOR_W-1:0] pick_start(logic [COUNT_W-1:0] c);
		int r;
		logic [63:0] span;
		r = $urandom_range(0, 99);
		if (sb.capacity == 0) begin
			if (r < 30)
				return rand48();
			if (r < 38)
				return {SECTOR_W{1'b1}} - SECTOR_W'($urandom_range(0, 600));
			return SECTOR_W'($urandom_range(0, 2000000));
		end
		if (r < 10)
			return rand48();
		if (r < 25)
			return LBA28_LIMIT[SECTOR_W-1:0] - SECTOR_W'($urandom_range(0, 600));
		if ({16'b0, sb.capacity} >= {32'b0, c}) begin
			span = {16'b0, sb.capacity} - {32'b0, c} + 1;
			span = {16'b0, rand48()} % span;
			return span[SECTOR_W-1:0];
		end
		return rand48();
	endfunction

	// a start followed by some of its next-chunk requests, flushes mixed in
	task automatic run_transfer();
		logic [COUNT_W-1:0] c;
		int max_next;
		int nexts;
		c = pick_count();
		send_request($urandom_range(0, 1) ? FN_WRITE : FN_READ, pick_start(c), c);
		max_next = $urandom_range(0, 6);
		nexts = 0;
		while (sb.active && nexts < max_next) begin
			if ($urandom_range(0, 9) == 0)
				send_request(FN_FLUSH, rand48(), $urandom);
			send_request(FN_NEXT, rand48(), $urandom);
			nexts++;
		end
	endtask

	// result side: random stalls, one long hold-off on request
	initial begin
		int stall;
		tf_item_t got;
		@(posedge arst_n);
		forever begin
			if (hold_flag) begin
				hold_flag = 0;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stall = burst ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
			got = '{rsp_ch.reg_write, rsp_ch.reg_index, rsp_ch.reg_value,
				rsp_ch.status, rsp_ch.sectors_left, rsp_ch.last};
			sb.check_item(got);
		end
	end

	// request side
	initial begin
		int target;
		int r;
		logic [SECTOR_W-1:0] cap;
		logic [7:0] ts;
		logic [4:0] hc;
		@(posedge arst_n);
		repeat (3) @(posedge clk);

		// no device: every function fails or idles
		write_regs(1'b0, '0, '0, '0);
		send_request(FN_READ, '0, 32'd1);
		send_request(FN_NEXT, rand48(), $urandom);
		send_request(FN_FLUSH, rand48(), $urandom);

		// chs with zero divisors
		wait_drained();
		write_regs(1'b1, '0, 8'd0, 5'd16);
		send_request(FN_WRITE, rand48(), 32'd10);
		send_request(FN_FLUSH, rand48(), $urandom);
		wait_drained();
		write_regs(1'b1, '0, 8'd63, 5'd0);
		send_request(FN_READ, rand48(), 32'd10);

		// chs at the top sector: cylinder overflow and sector wrap
		wait_drained();
		write_regs(1'b1, '0, 8'd63, 5'd16);
		send_request(FN_WRITE, '1, 32'd300);
		send_request(FN_NEXT, rand48(), $urandom);
		send_request(FN_NEXT, rand48(), $urandom);
		wait_drained();
		write_regs(1'b1, '0, 8'd255, 5'd1);
		send_request(FN_READ, '0, 32'd1);

		// lba28 capacity limit: boundary chunks, empty, out of range
		wait_drained();
		write_regs(1'b1, LBA28_LIMIT[SECTOR_W-1:0], 8'd0, 5'd0);
		send_request(FN_READ, LBA28_LIMIT[SECTOR_W-1:0] - 300, 32'd300);
		send_request(FN_NEXT, rand48(), $urandom);
		send_request(FN_READ, 48'd5, '0);
		send_request(FN_WRITE, LBA28_LIMIT[SECTOR_W-1:0], 32'd1);
		send_request(FN_FLUSH, rand48(), $urandom);

		// full capacity: lba48, flush during a transfer
		wait_drained();
		write_regs(1'b1, '1, 8'd255, 5'd16);
		send_request(FN_WRITE, 48'h0000_0FFF_FF00, '1);
		send_request(FN_FLUSH, rand48(), $urandom);
		send_request(FN_NEXT, rand48(), $urandom);

		// device lost mid transfer
		wait_drained();
		write_regs(1'b0, '1, 8'd255, 5'd16);
		send_request(FN_NEXT, rand48(), $urandom);
		send_request(FN_NEXT, rand48(), $urandom);

		// result side holds off while requests keep coming
		wait_drained();
		write_regs(1'b1, '1, 8'd1, 5'd1);
		burst = 1;
		hold_flag = 1;
		send_request(FN_READ, '0, 32'd4000);
		repeat (8) send_request(FN_NEXT, rand48(), $urandom);
		burst = 0;
		wait_drained();

		// random phases, each with its own register setting
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			wait_drained();
			r = $urandom_range(0, 99);
			if (r < 35)
				cap = '0;
			else if (r < 50)
				cap = LBA28_LIMIT[SECTOR_W-1:0];
			else if (r < 65)
				cap = '1;
			else if (r < 75)
				cap = LBA28_LIMIT[SECTOR_W-1:0] + 1;
			else
				cap = rand48() >> $urandom_range(0, 47);
			r = $urandom_range(0, 9);
			ts = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : (r == 2) ? 8'd1 :
				8'($urandom_range(1, 255));
			r = $urandom_range(0, 9);
			hc = (r == 0) ? 5'd0 : (r == 1) ? 5'd16 : (r == 2) ? 5'd1 :
				5'($urandom_range(1, 16));
			write_regs($urandom_range(0, 9) != 0, cap, ts, hc);
			burst = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(3, 8)) begin
				if ($urandom_range(0, 9) == 0)
					send_request(2'($urandom), rand48(), $urandom);
				else
					run_transfer();
			end
		end
		burst = 0;

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.due_items.size() == 0) begin
			$display("status: pass");
		end else begin
			if (sb.due_items.size() != 0)
				$display("%0t %0d expected items never came", $time, sb.due_items.size());
			$display("status: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire
